// ----- design/waypoint_steering_controller_unit_macros.svh -----
// assertion helpers for the waypoint steering controller
`ifndef WAYPOINT_STEERING_CONTROLLER_UNIT_MACROS_SVH
`define WAYPOINT_STEERING_CONTROLLER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/wsc_pkg.sv -----
`timescale 1ns / 1ps
package wsc_pkg;

  localparam int WaypointCount = 8;
  localparam int CordicSteps   = 13;
  localparam int AngW          = 16;
  localparam int CordW         = 36;

  localparam logic signed [AngW-1:0] AngPi     = 16'sd12868;
  localparam logic signed [AngW-1:0] AngHalfPi = 16'sd6434;
  localparam logic signed [AngW:0]   AngTwoPi  = 17'sd25736;

  // configuration register indexes
  localparam logic [2:0] RegTol   = 3'd0;
  localparam logic [2:0] RegBase  = 3'd1;
  localparam logic [2:0] RegGain  = 3'd2;
  localparam logic [2:0] RegThr   = 3'd3;
  localparam logic [2:0] RegRange = 3'd4;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDist  = 7'b0000010,
    StCmp   = 7'b0000100,
    StCord  = 7'b0001000,
    StMul   = 7'b0010000,
    StSpeed = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  // arctangent table, unsigned Q0.12
  function automatic logic [11:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    atan_lut = 12'd3217;
      4'd1:    atan_lut = 12'd1899;
      4'd2:    atan_lut = 12'd1003;
      4'd3:    atan_lut = 12'd509;
      4'd4:    atan_lut = 12'd256;
      4'd5:    atan_lut = 12'd128;
      4'd6:    atan_lut = 12'd64;
      4'd7:    atan_lut = 12'd32;
      4'd8:    atan_lut = 12'd16;
      4'd9:    atan_lut = 12'd8;
      4'd10:   atan_lut = 12'd4;
      4'd11:   atan_lut = 12'd2;
      4'd12:   atan_lut = 12'd1;
      default: atan_lut = 12'd0;
    endcase
  endfunction

endpackage

// ----- design/waypoint_steering_controller_unit.sv -----
`timescale 1ns / 1ps
// channel | signals                               | direction
// input   | in_valid_i, in_stall_o, 12 fields      | request into block
// output  | out_valid_o, out_stall_i, 5 fields     | result out of block
// config  | cfg_we_i, cfg_index_i, cfg_data_i      | register writes
// a load request writes the waypoint memory on acceptance; a step goes to StOut when
// halted, through StDist and StCmp when reached, else also through StCord, StMul and
// StSpeed, where two 13-step cordic runs on one shared rotator find the angle. the result
// sits in an output register; a new request is taken only once it has left.
// rst_ni clears the sequencer, slot and output valid and sets the configuration registers to defaults.
`include "waypoint_steering_controller_unit_macros.svh"
module waypoint_steering_controller_unit #(
  parameter int WAYPOINT_COUNT = wsc_pkg::WaypointCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [15:0]            pos_x_i,
  input  logic signed [15:0]            pos_y_i,
  input  logic signed [15:0]            north_x_i,
  input  logic signed [15:0]            north_y_i,
  input  logic [7:0]                    red_level_i,
  input  logic [7:0]                    green_level_i,
  input  logic [7:0]                    blue_level_i,
  input  logic [15:0]                   obstacle_range_i,
  input  logic [2:0]                    load_index_i,
  input  logic signed [15:0]            load_x_i,
  input  logic signed [15:0]            load_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            left_speed_o,
  output logic signed [15:0]            right_speed_o,
  output logic [2:0]                    target_slot_o,
  output logic                          reached_o,
  output logic                          halted_o
);
  import wsc_pkg::*;

  localparam int SlotW = (WAYPOINT_COUNT > 1) ? $clog2(WAYPOINT_COUNT) : 1;

  // configuration registers
  logic [12:0] tol_q, base_q;
  logic [11:0] gain_q;
  logic [7:0]  thr_q;
  logic [15:0] range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= 13'd384;
      base_q  <= 13'd988;
      gain_q  <= 12'd1024;
      thr_q   <= 8'd100;
      range_q <= 16'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTol:   tol_q   <= cfg_data_i[12:0];
        RegBase:  base_q  <= cfg_data_i[12:0];
        RegGain:  gain_q  <= cfg_data_i[11:0];
        RegThr:   thr_q   <= cfg_data_i[7:0];
        RegRange: range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // waypoint memory
  logic signed [15:0] wx_mem [WAYPOINT_COUNT];
  logic signed [15:0] wy_mem [WAYPOINT_COUNT];

  state_e state_q, state_d;
  logic [SlotW-1:0] slot_q;
  logic accept;
  logic [8:0] li_ext;

  assign in_stall_o = (state_q != StIdle) || out_valid_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign li_ext     = {6'd0, load_index_i};

  always_ff @(posedge clk_i) begin
    if (accept && kind_i && (li_ext < 9'(WAYPOINT_COUNT))) begin
      wx_mem[SlotW'(li_ext)] <= load_x_i;
      wy_mem[SlotW'(li_ext)] <= load_y_i;
    end
  end

  // step registers
  logic signed [16:0] dx_q, dy_q;
  logic signed [15:0] nx_q, ny_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [AngW-1:0]  cz_q, robot_q;
  logic [3:0] it_q;
  logic       pass_q;
  logic [33:0] d2_q;
  logic [25:0] t2_q;
  logic signed [17:0] beta_q;
  logic signed [30:0] prod_q;
  logic red_stop;

  assign red_stop = (red_level_i > thr_q) && (green_level_i < thr_q) &&
                    (blue_level_i < thr_q) && (obstacle_range_i < range_q);

  // shared cordic step
  logic signed [CordW-1:0] xs, ys, nx_c, ny_c;
  logic signed [AngW-1:0]  nz_c;
  logic signed [AngW-1:0]  tab;
  assign xs  = cx_q >>> it_q;
  assign ys  = cy_q >>> it_q;
  assign tab = AngW'(signed'({1'b0, atan_lut(it_q)}));
  always_comb begin
    if (!cy_q[CordW-1]) begin
      nx_c = cx_q + ys;
      ny_c = cy_q - xs;
      nz_c = cz_q + tab;
    end else begin
      nx_c = cx_q - ys;
      ny_c = cy_q + xs;
      nz_c = cz_q - tab;
    end
  end

  // pre-rotation of a vector into the right half plane
  // heading run: x is north_y, y is north_x; target run (loaded at end of pass 0): dx, dy
  logic signed [CordW-1:0] px, py;
  logic signed [AngW-1:0]  pz;
  logic signed [16:0] vx, vy;
  logic use_d;
  assign use_d = pass_q || (state_q == StCord);
  always_comb begin
    vx = use_d ? dx_q : 17'(ny_q);
    vy = use_d ? dy_q : 17'(nx_q);
    px = CordW'(vx) <<< 14;
    py = CordW'(vy) <<< 14;
    pz = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        px = CordW'(vy) <<< 14; py = -(CordW'(vx) <<< 14); pz = AngHalfPi;
      end else begin
        px = -(CordW'(vy) <<< 14); py = CordW'(vx) <<< 14; pz = -AngHalfPi;
      end
    end
  end

  logic signed [17:0] beta_raw, beta_w;
  logic signed [16:0] target_ang;
  assign target_ang = (dx_q == 0 && dy_q == 0) ? 17'sd0 : 17'(nz_c);
  always_comb begin
    beta_raw = 18'(robot_q) - 18'(target_ang);
    beta_w   = beta_raw;
    if (beta_raw >= 18'(AngPi))       beta_w = beta_raw - 18'(AngTwoPi);
    else if (beta_raw < -18'(AngPi))  beta_w = beta_raw + 18'(AngTwoPi);
  end

  logic signed [18:0] term;
  logic signed [19:0] lsum, rsum;
  assign term = 19'((prod_q + 31'sd2048) >>> 12);
  assign lsum = 20'(signed'({1'b0, base_q})) + 20'(term);
  assign rsum = 20'(signed'({1'b0, base_q})) - 20'(term);

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767)       sat16 = 16'sd32767;
    else if (v < -20'sd32768) sat16 = -16'sd32768;
    else                      sat16 = v[15:0];
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept && !kind_i) state_d = red_stop ? StOut : StDist;
      StDist:  state_d = StCmp;
      StCmp:   state_d = (d2_q < 34'(t2_q)) ? StOut : StCord;
      StCord:  if (it_q == 4'(CordicSteps - 1) && pass_q) state_d = StMul;
      StMul:   state_d = StSpeed;
      StSpeed: state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (state_q == StCmp && d2_q < 34'(t2_q))
        slot_q <= (32'(slot_q) == WAYPOINT_COUNT - 1) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (accept && !kind_i) begin
        dx_q  <= 17'(wx_mem[slot_q]) - 17'(pos_x_i);
        dy_q  <= 17'(wy_mem[slot_q]) - 17'(pos_y_i);
        nx_q  <= north_x_i;
        ny_q  <= north_y_i;
        t2_q  <= tol_q * tol_q;
        left_speed_o  <= '0;
        right_speed_o <= '0;
        reached_o     <= 1'b0;
        halted_o      <= red_stop;
        pass_q        <= 1'b0;
      end
      StDist: d2_q <= 34'(dx_q) * 34'(dx_q) + 34'(dy_q) * 34'(dy_q);
      StCmp: begin
        reached_o <= d2_q < 34'(t2_q);
        cx_q <= px; cy_q <= py; cz_q <= pz; it_q <= '0;
      end
      StCord: begin
        if (it_q == 4'(CordicSteps - 1)) begin
          if (!pass_q) begin
            robot_q <= (nx_q == 0 && ny_q == 0) ? '0 : nz_c;
            pass_q  <= 1'b1;
            cx_q <= px; cy_q <= py; cz_q <= pz; it_q <= '0;
          end else begin
            beta_q <= beta_w;
          end
        end else begin
          cx_q <= nx_c; cy_q <= ny_c; cz_q <= nz_c; it_q <= it_q + 1'b1;
        end
      end
      StMul: prod_q <= 31'(beta_q) * 31'(signed'({1'b0, gain_q}));
      StSpeed: begin
        left_speed_o  <= sat16(lsum);
        right_speed_o <= sat16(rsum);
      end
      default: ;
    endcase
  end

  assign target_slot_o = 3'(slot_q);

  `WSC_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, state_q != StIdle, in_stall_o)
  `WSC_ASSERT_NXT(a_out_after_seq, clk_i, rst_ni, state_q == StOut, out_valid_o)
  `WSC_ASSERT_IMP(a_one_flag, clk_i, rst_ni, out_valid_o, !(reached_o && halted_o))
endmodule

// ----- tb/tb_waypoint_steering_controller_unit.sv -----
`timescale 1ns / 1ps
module tb_waypoint_steering_controller_unit;
  import wsc_pkg::*;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [2:0]         target_slot;
    logic               reached;
    logic               halted;
  } steer_cmd_t;

  typedef struct {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] north_x;
    logic signed [15:0] north_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        range;
    logic [2:0]         load_index;
    logic signed [15:0] load_x;
    logic signed [15:0] load_y;
  } nav_req_t;

  localparam logic KindStep = 1'b0;
  localparam logic KindLoad = 1'b1;

  // steering predictor plus queue of expected commands
  class steer_scoreboard;
    longint wp_x[WaypointCount];
    longint wp_y[WaypointCount];
    int unsigned slot;
    longint tol, base, gain, thr, stop_rng;
    steer_cmd_t pending_cmds[$];
    int errors;
    int steps, halts, reaches, loads;

    function void reset_state();
      for (int i = 0; i < WaypointCount; i++) begin
        wp_x[i] = 0;
        wp_y[i] = 0;
      end
      slot = 0;
      tol = 384;
      base = 988;
      gain = 1024;
      thr = 100;
      stop_rng = 128;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        RegTol:   tol = val[12:0];
        RegBase:  base = val[12:0];
        RegGain:  gain = val[11:0];
        RegThr:   thr = val[7:0];
        RegRange: stop_rng = val;
        default: ;
      endcase
    endfunction

    // floor shift for negatives
    function longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v + (64'sd1 << s) - 1) >>> s);
    endfunction

    function longint heading(longint y, longint x);
      longint z, t, xs, ys;
      logic [11:0] step_ang;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 16384;
      y = y * 16384;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = AngHalfPi;
        end else begin
          t = x; x = -y; y = t; z = -AngHalfPi;
        end
      end
      for (int i = 0; i < CordicSteps; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        step_ang = atan_lut(4'(i));
        if (y >= 0) begin
          x += ys; y -= xs; z += step_ang;
        end else begin
          x -= ys; y += xs; z -= step_ang;
        end
      end
      return z;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_request(nav_req_t r);
      steer_cmd_t c;
      longint dx, dy, beta, term;
      if (r.kind == KindLoad) begin
        wp_x[r.load_index] = r.load_x;
        wp_y[r.load_index] = r.load_y;
        loads++;
        return;
      end
      steps++;
      c = '0;
      if (r.red > thr && r.green < thr && r.blue < thr && r.range < stop_rng) begin
        c.halted = 1'b1;
        halts++;
      end else begin
        dx = wp_x[slot] - longint'(r.pos_x);
        dy = wp_y[slot] - longint'(r.pos_y);
        if (dx * dx + dy * dy < tol * tol) begin
          c.reached = 1'b1;
          slot = (slot + 1) % WaypointCount;
          reaches++;
        end else begin
          beta = heading(r.north_x, r.north_y) - heading(dy, dx);
          while (beta >= AngPi) beta -= AngTwoPi;
          while (beta < -AngPi) beta += AngTwoPi;
          term = floor_shift(gain * beta + 2048, 12);
          c.left_speed = 16'(clip16(base + term));
          c.right_speed = 16'(clip16(base - term));
        end
      end
      c.target_slot = 3'(slot);
      pending_cmds.push_back(c);
    endfunction

    function void check_result(steer_cmd_t got);
      steer_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.left_speed !== want.left_speed) begin
        $display("%0t: left_speed exp %0d got %0d", $time, want.left_speed, got.left_speed);
        errors++;
      end
      if (got.right_speed !== want.right_speed) begin
        $display("%0t: right_speed exp %0d got %0d", $time, want.right_speed,
                 got.right_speed);
        errors++;
      end
      if (got.target_slot !== want.target_slot) begin
        $display("%0t: target_slot exp %0d got %0d", $time, want.target_slot,
                 got.target_slot);
        errors++;
      end
      if (got.reached !== want.reached) begin
        $display("%0t: reached exp %0b got %0b", $time, want.reached, got.reached);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $display("%0t: halted exp %0b got %0b", $time, want.halted, got.halted);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, north_x_i = '0, north_y_i = '0;
  logic [7:0] red_level_i = '0, green_level_i = '0, blue_level_i = '0;
  logic [15:0] obstacle_range_i = '0;
  logic [2:0] load_index_i = '0;
  logic signed [15:0] load_x_i = '0, load_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] left_speed_o, right_speed_o;
  logic [2:0] target_slot_o;
  logic reached_o, halted_o;

  waypoint_steering_controller_unit dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  steer_scoreboard sb = new();
  longint unsigned cycle_count = 0;
  int stall_mode = 0;
  logic signed [15:0] slot_x[WaypointCount];
  logic signed [15:0] slot_y[WaypointCount];

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern: modes cycle between none, sparse, heavy
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({left_speed_o, right_speed_o, target_slot_o, reached_o, halted_o});
  end

  task automatic send(nav_req_t r);
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    pos_x_i <= r.pos_x;
    pos_y_i <= r.pos_y;
    north_x_i <= r.north_x;
    north_y_i <= r.north_y;
    red_level_i <= r.red;
    green_level_i <= r.green;
    blue_level_i <= r.blue;
    obstacle_range_i <= r.range;
    load_index_i <= r.load_index;
    load_x_i <= r.load_x;
    load_y_i <= r.load_y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    if (r.kind == KindLoad) begin
      slot_x[r.load_index] = r.load_x;
      slot_y[r.load_index] = r.load_y;
    end
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic nav_req_t blank_req();
    nav_req_t r;
    r.kind = KindStep;
    r.pos_x = 16'($urandom);
    r.pos_y = 16'($urandom);
    r.north_x = 16'($signed($urandom_range(0, 32768)) - 16384);
    r.north_y = 16'($signed($urandom_range(0, 32768)) - 16384);
    r.red = 8'($urandom);
    r.green = 8'($urandom);
    r.blue = 8'($urandom);
    r.range = 16'($urandom);
    r.load_index = 3'($urandom);
    r.load_x = 16'($urandom);
    r.load_y = 16'($urandom);
    return r;
  endfunction

  // random step: sometimes near the waypoint, sometimes red/near
  function automatic nav_req_t random_step();
    nav_req_t r;
    r = blank_req();
    case ($urandom_range(0, 5))
      0: begin
        r.pos_x = slot_x[sb.slot] + 16'($signed($urandom_range(0, 600)) - 300);
        r.pos_y = slot_y[sb.slot] + 16'($signed($urandom_range(0, 600)) - 300);
      end
      1: begin
        r.red = 8'($urandom_range(sb.thr < 255 ? sb.thr + 1 : 255, 255));
        r.green = 8'($urandom_range(0, sb.thr > 0 ? sb.thr - 1 : 0));
        r.blue = 8'($urandom_range(0, sb.thr > 0 ? sb.thr - 1 : 0));
        r.range = 16'($urandom_range(0, sb.stop_rng));
      end
      2: begin
        r.pos_x = slot_x[sb.slot];
        r.pos_y = slot_y[sb.slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  nav_req_t req;

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot written before any step reads it
    for (int i = 0; i < WaypointCount; i++) begin
      req = blank_req();
      req.kind = KindLoad;
      req.load_index = 3'(i);
      req.load_x = (i == 0) ? 16'sh8000 : (i == 1) ? 16'sh7fff : 16'($urandom);
      req.load_y = (i == 0) ? 16'sh7fff : (i == 1) ? 16'sh8000 : 16'($urandom);
      send(req);
    end

    // directed steps: field extremes, red stop, reach, zero vector, boundaries
    req = blank_req();
    req.pos_x = 16'sh7fff; req.pos_y = 16'sh8000;
    req.north_x = -16'sd16384; req.north_y = 16'sd16384; req.red = 8'd0;
    send(req);
    req.pos_x = 16'sh8000; req.pos_y = 16'sh7fff;
    req.north_x = 16'sd0; req.north_y = 16'sd0;
    req.red = 8'd255; req.green = 8'd0; req.blue = 8'd0;
    req.range = 16'd0;
    send(req);
    req.range = 16'hffff; req.green = 8'd255; req.blue = 8'd255;
    send(req);
    req.pos_x = slot_x[sb.slot]; req.pos_y = slot_y[sb.slot];
    req.north_x = 16'sd16384; req.north_y = -16'sd16384;
    send(req);
    req.red = 8'd101; req.green = 8'd99; req.blue = 8'd99; req.range = 16'd127;
    send(req);
    req.red = 8'd100;
    send(req);
    req = blank_req(); req.north_x = -16'sd16384; req.north_y = 16'sd0;
    send(req);
    req.north_x = 16'sd0; req.north_y = -16'sd16384;
    send(req);
    drain();

    // extreme gains and speeds, zero tolerance
    write_cfg(RegTol, 16'd0);
    write_cfg(RegBase, 16'd8191);
    write_cfg(RegGain, 16'd4095);
    write_cfg(RegThr, 16'd255);
    write_cfg(RegRange, 16'hffff);
    for (int i = 0; i < 6; i++) send(random_step());
    drain();
    write_cfg(RegBase, 16'd0);
    write_cfg(RegThr, 16'd0);
    for (int i = 0; i < 6; i++) send(random_step());
    drain();

    // random phases with different settings and stall patterns
    for (int ph = 0; ph < 4; ph++) begin
      stall_mode = ph % 3;
      write_cfg(RegTol, ph == 3 ? 16'd8191 : 16'($urandom_range(100, 1500)));
      write_cfg(RegBase, 16'($urandom_range(0, 8191)));
      write_cfg(RegGain, 16'($urandom_range(0, 4095)));
      write_cfg(RegThr, 16'($urandom_range(0, 255)));
      write_cfg(RegRange, 16'($urandom));
      for (int n = 0; n < 95; ) begin
        for (int b = $urandom_range(1, 8); b > 0 && n < 95; b--, n++) begin
          if ($urandom_range(0, 5) == 0) begin
            req = blank_req();
            req.kind = KindLoad;
          end else begin
            req = random_step();
          end
          send(req);
        end
        if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 40));
      end
      drain();
    end

    $display("tb: %0d steps (%0d halted, %0d reached), %0d loads over several settings",
             sb.steps, sb.halts, sb.reaches, sb.loads);
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
